FILE: design/tbls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbls_pkg
// Shared types and constants for the time-bucketed latency statistics block.
// ----------------------------------------------------------------------------
package tbls_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int TS_W    = 32;
    localparam int LAT_W   = 24;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 56;
    localparam int LEN_W   = 16;
    localparam int OIDX_W  = 6;

    localparam logic [LEN_W-1:0] SLOT_LEN_RESET = LEN_W'(60);

    typedef struct packed {
        logic [TS_W-1:0]  timestamp;
        logic [LAT_W-1:0] latency;
    } in_word_t;

    typedef struct packed {
        logic [OIDX_W-1:0] slot_index;
        logic [LAT_W-1:0]  slot_minimum;
        logic [LAT_W-1:0]  slot_maximum;
        logic [CNT_W-1:0]  slot_count;
        logic [LAT_W-1:0]  slot_average;
        logic              opened_slot;
        logic              evicted_oldest;
    } out_word_t;

    typedef struct packed {
        logic [LAT_W-1:0] minimum;
        logic [LAT_W-1:0] maximum;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

endpackage

`default_nettype wire

FILE: design/tbls_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbls_div
// Restoring divider, one quotient bit per cycle, for the slot average.
// The quotient is known to fit in the latency width since sum < count * 2^LAT_W.
// ----------------------------------------------------------------------------
module tbls_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tbls_pkg::SUM_W-1:0]  dividend,
    input  wire logic [tbls_pkg::CNT_W-1:0]  divisor,
    output logic                             busy,
    output logic [tbls_pkg::LAT_W-1:0]       quotient
);

    localparam int QW    = tbls_pkg::LAT_W;
    localparam int RW    = tbls_pkg::CNT_W;
    localparam int STEPW = $clog2(QW + 1);

    logic [RW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [RW-1:0]    dvs_reg;
    logic [STEPW-1:0] step_reg;
    logic             busy_reg;
    logic [RW+1:0]    trial;
    logic             neg;

    assign trial = {1'b0, rem_reg, quo_reg[QW-1]} - {2'b00, dvs_reg};
    assign neg   = trial[RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEPW'(QW);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEPW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[tbls_pkg::SUM_W-1:QW];
            quo_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= neg ? {rem_reg[RW-2:0], quo_reg[QW-1]} : trial[RW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ~neg};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/tbls_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbls_dp
// Datapath: ring pointers, slot memory, slot update, divider, result register.
// ----------------------------------------------------------------------------
module tbls_dp #(
    parameter int SLOTS = tbls_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tbls_pkg::cmd_t              cmd,
    output tbls_pkg::status_t                status,
    input  wire tbls_pkg::in_word_t          in_word,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tbls_pkg::LEN_W-1:0]  cfg_wr_data,
    output tbls_pkg::out_word_t              out_word
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [USED_W-1:0] FULL_USED = USED_W'(SLOTS);

    tbls_pkg::entry_t mem_ram [SLOTS];

    logic [tbls_pkg::LEN_W-1:0] slot_len_reg;
    logic [IDX_W-1:0]           oldest_reg;
    logic [IDX_W-1:0]           newest_reg;
    logic [USED_W-1:0]          used_reg;
    logic [tbls_pkg::TS_W-1:0]  open_time_reg;
    logic                       started_reg;

    logic [tbls_pkg::TS_W-1:0]  ts_reg;
    logic [tbls_pkg::LAT_W-1:0] lat_reg;
    logic                       opened_reg;
    logic                       evicted_reg;
    tbls_pkg::entry_t           rd_entry_reg;
    tbls_pkg::entry_t           upd_reg;
    tbls_pkg::out_word_t        out_reg;

    logic [tbls_pkg::TS_W-1:0]  diff;
    logic                       join_slot;
    logic [IDX_W-1:0]           newest_inc;
    logic [IDX_W-1:0]           oldest_inc;
    logic [IDX_W-1:0]           oldest_next;
    logic [IDX_W-1:0]           newest_next;
    logic [USED_W-1:0]          used_next;
    logic                       opened_next;
    logic                       evicted_next;
    tbls_pkg::entry_t           upd_next;
    logic                       div_busy;
    logic [tbls_pkg::LAT_W-1:0] quotient;

    assign diff       = ts_reg - open_time_reg;
    assign join_slot  = diff[tbls_pkg::TS_W-1]
                        || (diff < {{(tbls_pkg::TS_W-tbls_pkg::LEN_W){1'b0}}, slot_len_reg});
    assign newest_inc = (newest_reg == LAST_IDX) ? '0 : newest_reg + 1'b1;
    assign oldest_inc = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;

    // ring pointer decision
    always_comb
    begin
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        used_next    = used_reg;
        opened_next  = 1'b0;
        evicted_next = 1'b0;
        if (!started_reg)
        begin
            oldest_next = '0;
            newest_next = '0;
            used_next   = USED_W'(1);
            opened_next = 1'b1;
        end
        else if (!join_slot)
        begin
            opened_next = 1'b1;
            if (used_reg < FULL_USED)
            begin
                newest_next = newest_inc;
                used_next   = used_reg + 1'b1;
            end
            else
            begin
                newest_next  = oldest_reg;
                oldest_next  = oldest_inc;
                evicted_next = 1'b1;
            end
        end
    end

    // slot update
    always_comb
    begin
        upd_next = rd_entry_reg;
        if (opened_reg)
        begin
            upd_next.minimum = lat_reg;
            upd_next.maximum = lat_reg;
            upd_next.count   = tbls_pkg::CNT_W'(1);
            upd_next.sum     = tbls_pkg::SUM_W'(lat_reg);
        end
        else
        begin
            if (lat_reg < rd_entry_reg.minimum)
            begin
                upd_next.minimum = lat_reg;
            end
            if (lat_reg > rd_entry_reg.maximum)
            begin
                upd_next.maximum = lat_reg;
            end
            if (rd_entry_reg.count != '1)
            begin
                upd_next.count = rd_entry_reg.count + 1'b1;
                upd_next.sum   = rd_entry_reg.sum + tbls_pkg::SUM_W'(lat_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_len_reg  <= tbls_pkg::SLOT_LEN_RESET;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            used_reg      <= '0;
            open_time_reg <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                slot_len_reg <= cfg_wr_data;
            end
            if (cmd.decide)
            begin
                oldest_reg  <= oldest_next;
                newest_reg  <= newest_next;
                used_reg    <= used_next;
                started_reg <= 1'b1;
                if (opened_next)
                begin
                    open_time_reg <= ts_reg;
                end
            end
        end
    end

    // payload registers and slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ts_reg  <= in_word.timestamp;
            lat_reg <= in_word.latency;
        end
        if (cmd.decide)
        begin
            opened_reg   <= opened_next;
            evicted_reg  <= evicted_next;
            rd_entry_reg <= mem_ram[newest_next];
        end
        if (cmd.update)
        begin
            mem_ram[newest_reg] <= upd_next;
            upd_reg             <= upd_next;
        end
        if (cmd.load_out)
        begin
            out_reg.slot_index     <= tbls_pkg::OIDX_W'(newest_reg);
            out_reg.slot_minimum   <= upd_reg.minimum;
            out_reg.slot_maximum   <= upd_reg.maximum;
            out_reg.slot_count     <= upd_reg.count;
            out_reg.slot_average   <= quotient;
            out_reg.opened_slot    <= opened_reg;
            out_reg.evicted_oldest <= evicted_reg;
        end
    end

    tbls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .dividend (upd_next.sum),
        .divisor  (upd_next.count),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.div_busy = div_busy;
    assign out_word        = out_reg;

    // ring occupancy never goes beyond the slot count
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL_USED)
        else $error("slot fill count above ring size");

    // oldest pointer only moves once the ring is full
    a_oldest_still: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != FULL_USED) |-> (oldest_reg == '0))
        else $error("oldest slot moved before ring filled");

    // a full ring keeps newest directly behind oldest
    a_full_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == FULL_USED) |-> (newest_inc == oldest_reg))
        else $error("newest and oldest slots not adjacent on full ring");

    // the average is never taken from a divider still running
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !div_busy)
        else $error("result loaded while divider busy");

endmodule

`default_nettype wire

FILE: design/tbls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbls_ctrl
// Controller: sequences capture, ring decision, slot update, divide and
// result hand-off, and owns both handshakes.
// ----------------------------------------------------------------------------
module tbls_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tbls_pkg::cmd_t          cmd,
    input  wire tbls_pkg::status_t  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UPDATE,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free     = !out_valid_reg || out_ready;
    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.capture  = in_valid && in_ready;
    assign cmd.decide   = (state_reg == S_DECIDE);
    assign cmd.update   = (state_reg == S_UPDATE);
    assign cmd.load_out = (state_reg == S_FINISH) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!status.div_busy)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/time_bucketed_latency_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_bucketed_latency_stats
// Ring of time slots keeping min, max, count, sum and floored average of
// latency samples per slot.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    in_word_t
//   out      output     out_valid / out_ready  out_word_t
//   cfg      input      cfg_wr_en              slot_length (16 bit)
//
// from acceptance to result: decide and slot read, update, one divider step per
// quotient bit, divider idle check and result load; a new word is taken once
// the previous one has reached the result register
// reset gives slot_length 60 and an empty ring; slot memory needs no clearing
// a stalled result only holds the block once the next result is ready
// ----------------------------------------------------------------------------
module time_bucketed_latency_stats #(
    parameter int SLOTS = tbls_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tbls_pkg::in_word_t          in_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tbls_pkg::out_word_t              out_word,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tbls_pkg::LEN_W-1:0]  cfg_wr_data
);

    tbls_pkg::cmd_t    cmd;
    tbls_pkg::status_t status;

    tbls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tbls_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_word     (in_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_word    (out_word)
    );

endmodule

`default_nettype wire

FILE: tb/sv/latency_stats_checker.sv
// ----------------------------------------------------------------------------
// latency_stats_checker
// Watches the input, result and register ports of the latency statistics
// block. Keeps its own ring of slots, works out the result each accepted word
// should give and compares every accepted result with the oldest one waiting.
// Failures, the number of results still due and a few totals go to the top.
// ----------------------------------------------------------------------------
module latency_stats_checker #(
    parameter int SLOTS = tbls_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  tbls_pkg::in_word_t         in_word,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  tbls_pkg::out_word_t        out_word,
    input  logic                       cfg_wr_en,
    input  logic [tbls_pkg::LEN_W-1:0] cfg_wr_data,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_count,
    output int                         opened_count,
    output int                         evicted_count
);

    logic [tbls_pkg::LEN_W-1:0] slot_len;
    logic [tbls_pkg::LAT_W-1:0] min_mem [SLOTS];
    logic [tbls_pkg::LAT_W-1:0] max_mem [SLOTS];
    logic [tbls_pkg::CNT_W-1:0] cnt_mem [SLOTS];
    logic [tbls_pkg::SUM_W-1:0] sum_mem [SLOTS];
    int unsigned                oldest_pos;
    int unsigned                newest_pos;
    int unsigned                used_slots;
    logic [tbls_pkg::TS_W-1:0]  open_ts;
    bit                         seen_first;
    tbls_pkg::out_word_t        slot_stats_q [$];
    int                         errors = 0;
    int                         results = 0;
    int                         opens = 0;
    int                         evictions = 0;

    function automatic void start_slot(int unsigned pos,
                                       logic [tbls_pkg::LAT_W-1:0] lat);
        min_mem[pos] = lat;
        max_mem[pos] = lat;
        cnt_mem[pos] = tbls_pkg::CNT_W'(1);
        sum_mem[pos] = tbls_pkg::SUM_W'(lat);
    endfunction

    // folds one word into the ring and returns the stats of the slot it touched
    function automatic tbls_pkg::out_word_t fold_sample(tbls_pkg::in_word_t w);
        logic [tbls_pkg::TS_W-1:0]  diff;
        logic [tbls_pkg::SUM_W-1:0] avg;
        tbls_pkg::out_word_t        r;
        r = '0;
        diff = w.timestamp - open_ts;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            oldest_pos = 0;
            newest_pos = 0;
            used_slots = 1;
            open_ts = w.timestamp;
            start_slot(0, w.latency);
            r.opened_slot = 1'b1;
        end
        else if (diff[tbls_pkg::TS_W-1] || diff < tbls_pkg::TS_W'(slot_len))
        begin
            if (w.latency < min_mem[newest_pos])
                min_mem[newest_pos] = w.latency;
            if (w.latency > max_mem[newest_pos])
                max_mem[newest_pos] = w.latency;
            if (cnt_mem[newest_pos] != '1)
            begin
                cnt_mem[newest_pos] = cnt_mem[newest_pos] + 1'b1;
                sum_mem[newest_pos] = sum_mem[newest_pos]
                                      + tbls_pkg::SUM_W'(w.latency);
            end
        end
        else
        begin
            if (used_slots < SLOTS)
            begin
                newest_pos = (newest_pos + 1) % SLOTS;
                used_slots++;
            end
            else
            begin
                newest_pos = oldest_pos;
                oldest_pos = (oldest_pos + 1) % SLOTS;
                r.evicted_oldest = 1'b1;
            end
            start_slot(newest_pos, w.latency);
            open_ts = w.timestamp;
            r.opened_slot = 1'b1;
        end
        avg = sum_mem[newest_pos] / tbls_pkg::SUM_W'(cnt_mem[newest_pos]);
        r.slot_index   = tbls_pkg::OIDX_W'(newest_pos);
        r.slot_minimum = min_mem[newest_pos];
        r.slot_maximum = max_mem[newest_pos];
        r.slot_count   = cnt_mem[newest_pos];
        r.slot_average = avg[tbls_pkg::LAT_W-1:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tbls_pkg::out_word_t want;
        if (!rst_n)
        begin
            slot_len = tbls_pkg::SLOT_LEN_RESET;
            oldest_pos = 0;
            newest_pos = 0;
            used_slots = 0;
            open_ts = '0;
            seen_first = 1'b0;
            slot_stats_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                slot_len = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                results++;
                if (slot_stats_q.size() == 0)
                begin
                    $error("result word with nothing outstanding: %0h", out_word);
                    errors++;
                end
                else
                begin
                    want = slot_stats_q.pop_front();
                    compare_field("slot_index", want.slot_index, out_word.slot_index);
                    compare_field("slot_minimum", want.slot_minimum, out_word.slot_minimum);
                    compare_field("slot_maximum", want.slot_maximum, out_word.slot_maximum);
                    compare_field("slot_count", want.slot_count, out_word.slot_count);
                    compare_field("slot_average", want.slot_average, out_word.slot_average);
                    compare_field("opened_slot", want.opened_slot, out_word.opened_slot);
                    compare_field("evicted_oldest", want.evicted_oldest,
                                  out_word.evicted_oldest);
                end
            end
            if (in_valid && in_ready)
            begin
                want = fold_sample(in_word);
                slot_stats_q.push_back(want);
                if (want.opened_slot)
                    opens++;
                if (want.evicted_oldest)
                    evictions++;
            end
        end
        fail_count    <= errors;
        pending_count <= slot_stats_q.size();
        result_count  <= results;
        opened_count  <= opens;
        evicted_count <= evictions;
    end

endmodule

FILE: tb/sv/tb_time_bucketed_latency_stats.sv
// ----------------------------------------------------------------------------
// tb_time_bucketed_latency_stats
// Drives timestamped latency words into the block under a series of slot
// lengths, from zero to the widest, with bursty input and a stalling result
// side. A short directed run covers the first word, joins from the past,
// wrap of the time counter and the exact slot boundary; random runs then fill
// and recycle the ring. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_time_bucketed_latency_stats;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_WORDS    = 88;
    localparam int FIXED_PHASES   = 12;
    localparam int RANDOM_PHASES  = 2;
    localparam logic [tbls_pkg::LEN_W-1:0] PHASE_LEN [FIXED_PHASES] = '{
        16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd7, 16'd60,
        16'd1000, 16'd0, 16'd3, 16'hFFFF, 16'd25, 16'd1
    };

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    tbls_pkg::in_word_t         in_word;
    logic                       out_valid;
    logic                       out_ready;
    tbls_pkg::out_word_t        out_word;
    logic                       cfg_wr_en;
    logic [tbls_pkg::LEN_W-1:0] cfg_wr_data;

    int fail_count;
    int pending_count;
    int result_count;
    int opened_count;
    int evicted_count;

    logic [tbls_pkg::TS_W-1:0] cur_ts;
    int                        burst_left;
    bit                        gapless;
    int                        words_sent;
    int                        idle_cycles;
    int                        ready_mode;
    int                        ready_left;
    logic [31:0]               ready_pattern;
    int unsigned               ready_phase;

    time_bucketed_latency_stats u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    latency_stats_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .opened_count  (opened_count),
        .evicted_count (evicted_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side stall pattern
    initial
    begin
        out_ready <= 1'b0;
        ready_left = 0;
        ready_phase = 0;
    end

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(30, 300);
            ready_pattern = $urandom() | 32'h1;
        end
        else
            ready_left--;
        ready_phase++;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ready_pattern[ready_phase % 32];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [tbls_pkg::TS_W-1:0] ts,
                             input logic [tbls_pkg::LAT_W-1:0] lat);
        int gap;
        if (!gapless && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_word  <= {ts, lat};
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic set_slot_length(input logic [tbls_pkg::LEN_W-1:0] len);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [tbls_pkg::LEN_W-1:0] len, input int count);
        logic [tbls_pkg::TS_W-1:0]  span;
        logic [tbls_pkg::TS_W-1:0]  ts;
        logic [tbls_pkg::LAT_W-1:0] lat;
        int                         pick;
        gapless = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        cur_ts = $urandom();
        span = (len == 0) ? tbls_pkg::TS_W'(4) : 2 * tbls_pkg::TS_W'(len);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                cur_ts = cur_ts + $urandom_range(0, span);
            else if (pick < 64)
                cur_ts = cur_ts + tbls_pkg::TS_W'(len);
            else if (pick < 68)
                cur_ts = cur_ts + tbls_pkg::TS_W'(len) - 1'b1;
            else if (pick < 78)
                cur_ts = cur_ts - $urandom_range(1, span);
            else if (pick < 83)
                cur_ts = cur_ts + 32'h7FFF_FFFF;
            else if (pick < 88)
                cur_ts = $urandom();
            ts = cur_ts;
            // far in the past seen as a signed distance
            if (pick >= 88 && pick < 94)
                ts = cur_ts + 32'h8000_0000;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                lat = '0;
            else if (pick == 1)
                lat = '1;
            else if (pick == 2)
                lat = tbls_pkg::LAT_W'($urandom_range(0, 15));
            else
                lat = tbls_pkg::LAT_W'($urandom());
            send_word(ts, lat);
        end
    endtask

    initial
    begin
        in_valid    <= 1'b0;
        in_word     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= tbls_pkg::SLOT_LEN_RESET;
        rst_n       <= 1'b0;
        burst_left = 0;
        gapless = 1'b0;
        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default slot length, first word, boundary, past and wrap
        send_word(32'd100, 24'd500);
        send_word(32'd130, 24'd0);
        send_word(32'd159, 24'hFFFFFF);
        send_word(32'd90, 24'd7);
        send_word(32'd160, 24'd1000);
        send_word(32'd160 + 32'h8000_0000, 24'd5);
        send_word(32'd160 + 32'h7FFF_FFFF, 24'd12);
        send_word(32'hFFFF_FFFF, 24'hFFFFFF);
        send_word(32'h0000_0010, 24'd0);
        send_word(32'h0000_003A, 24'd3);
        send_word(32'h0000_003B, 24'd9);
        send_word(32'h0000_003B, 24'hFFFFFF);
        send_word(32'h0000_0000, 24'd0);
        send_word(32'h5555_5555, 24'h555555);
        send_word(32'hAAAA_AAAA, 24'hAAAAAA);

        for (int p = 0; p < FIXED_PHASES; p++)
        begin
            set_slot_length(PHASE_LEN[p]);
            run_phase(PHASE_LEN[p], PHASE_WORDS);
        end
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            cfg_wr_data <= cfg_wr_data;
            begin
                logic [tbls_pkg::LEN_W-1:0] len;
                len = tbls_pkg::LEN_W'($urandom_range(1, 65535));
                set_slot_length(len);
                run_phase(len, PHASE_WORDS);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words, checked %0d results over %0d slot lengths",
                 words_sent, result_count, 1 + FIXED_PHASES + RANDOM_PHASES);
        $display("%0d slots opened, %0d by reusing the oldest slot",
                 opened_count, evicted_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/tbls_pkg.sv
design/tbls_div.sv
design/tbls_dp.sv
design/tbls_ctrl.sv
design/time_bucketed_latency_stats.sv
tb/sv/latency_stats_checker.sv
tb/sv/tb_time_bucketed_latency_stats.sv
